[rtl/core/apcf_pkg.sv]
// Package with the shared types and codes of the audio player command framer.
`timescale 1ns / 1ps

package apcf_pkg;

	// Request codes carried in req_type.
	localparam logic [3:0] REQ_RESET        = 4'd0;
	localparam logic [3:0] REQ_CARD         = 4'd1;
	localparam logic [3:0] REQ_PLAY         = 4'd2;
	localparam logic [3:0] REQ_PAUSE        = 4'd3;
	localparam logic [3:0] REQ_TOGGLE       = 4'd4;
	localparam logic [3:0] REQ_NEXT         = 4'd5;
	localparam logic [3:0] REQ_PREV         = 4'd6;
	localparam logic [3:0] REQ_RESTART      = 4'd7;
	localparam logic [3:0] REQ_TRACK        = 4'd8;
	localparam logic [3:0] REQ_FOLDER_TRACK = 4'd9;
	localparam logic [3:0] REQ_VOLUME       = 4'd10;
	localparam logic [3:0] REQ_SLEEP        = 4'd11;

	// Player command bytes.
	localparam logic [7:0] CMD_NEXT         = 8'h01;
	localparam logic [7:0] CMD_PREV         = 8'h02;
	localparam logic [7:0] CMD_TRACK        = 8'h03;
	localparam logic [7:0] CMD_VOLUME       = 8'h06;
	localparam logic [7:0] CMD_CARD         = 8'h09;
	localparam logic [7:0] CMD_SLEEP        = 8'h0A;
	localparam logic [7:0] CMD_RESET        = 8'h0C;
	localparam logic [7:0] CMD_PLAY         = 8'h0D;
	localparam logic [7:0] CMD_PAUSE        = 8'h0E;
	localparam logic [7:0] CMD_FOLDER_TRACK = 8'h0F;

	// Fixed frame bytes.
	localparam logic [7:0] FRAME_START   = 8'h7E;
	localparam logic [7:0] FRAME_VERSION = 8'hFF;
	localparam logic [7:0] FRAME_LENGTH  = 8'h06;
	localparam logic [7:0] FRAME_STOP    = 8'hEF;

	// Byte positions within a frame.
	localparam logic [3:0] IDX_START   = 4'd0;
	localparam logic [3:0] IDX_VERSION = 4'd1;
	localparam logic [3:0] IDX_LENGTH  = 4'd2;
	localparam logic [3:0] IDX_CMD     = 4'd3;
	localparam logic [3:0] IDX_ACK     = 4'd4;
	localparam logic [3:0] IDX_PAR_HI  = 4'd5;
	localparam logic [3:0] IDX_PAR_LO  = 4'd6;
	localparam logic [3:0] IDX_CHK_HI  = 4'd7;
	localparam logic [3:0] IDX_CHK_LO  = 4'd8;
	localparam logic [3:0] IDX_STOP    = 4'd9;

	// Limits of the stored player state.
	localparam logic [15:0] TRACK_MAX  = 16'd999;
	localparam logic [15:0] TRACK_MIN  = 16'd1;
	localparam logic [7:0]  VOLUME_MAX = 8'd30;

	// Configuration register indexes and port widths.
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_REQUEST  = 8'd1;

	// Frames to be sent for one request.
	typedef struct packed {
		logic        emit;
		logic [7:0]  cmd;
		logic [15:0] param;
		logic        two;
	} frame_desc_t;

endpackage

[rtl/core/apcf_if.sv]
// Channel interfaces of the audio player command framer: requests, frame bytes, configuration.
`timescale 1ns / 1ps

interface apcf_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [15:0] track_number;
	logic [7:0]  folder_number;
	logic [7:0]  volume_level;

	modport source (output valid, req_type, track_number, folder_number, volume_level,
		input ready);
	modport sink (input valid, req_type, track_number, folder_number, volume_level,
		output ready);
endinterface

interface apcf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	logic       last;

	modport source (output valid, frame_byte, frame_end, last, input ready);
	modport sink (input valid, frame_byte, frame_end, last, output ready);
endinterface

interface apcf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [apcf_pkg::CFG_IDX_W-1:0]  index;
	logic [apcf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/apcf_req_state.sv]
// Player state registers and request decoding into frame descriptors.
`timescale 1ns / 1ps

module apcf_req_state (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  link_enabled,
	input  logic [3:0]            req_type,
	input  logic [15:0]           track_number,
	input  logic [7:0]            folder_number,
	input  logic [7:0]            volume_level,
	output apcf_pkg::frame_desc_t desc
);

	logic [15:0] track_q;
	logic [7:0]  folder_q;
	logic [4:0]  volume_q;
	logic        playing_q;

	logic [15:0] track_d;
	logic [7:0]  folder_d;
	logic [4:0]  volume_d;
	logic        playing_d;
	logic        known;
	logic [4:0]  vol_sat;

	// Decode the request against the current state.
	always_comb begin
		track_d   = track_q;
		folder_d  = folder_q;
		volume_d  = volume_q;
		playing_d = playing_q;
		known     = 1'b1;
		desc.cmd  = apcf_pkg::CMD_PLAY;
		desc.param = 16'h0000;
		desc.two  = 1'b0;
		vol_sat   = (volume_level > apcf_pkg::VOLUME_MAX) ? apcf_pkg::VOLUME_MAX[4:0]
			: volume_level[4:0];
		case (req_type)
			apcf_pkg::REQ_RESET: begin
				desc.cmd  = apcf_pkg::CMD_RESET;
				playing_d = 1'b0;
			end
			apcf_pkg::REQ_CARD: begin
				desc.cmd   = apcf_pkg::CMD_CARD;
				desc.param = 16'h0002;
			end
			apcf_pkg::REQ_PLAY: begin
				desc.cmd  = apcf_pkg::CMD_PLAY;
				playing_d = 1'b1;
			end
			apcf_pkg::REQ_PAUSE: begin
				desc.cmd  = apcf_pkg::CMD_PAUSE;
				playing_d = 1'b0;
			end
			apcf_pkg::REQ_TOGGLE: begin
				desc.cmd  = playing_q ? apcf_pkg::CMD_PAUSE : apcf_pkg::CMD_PLAY;
				playing_d = !playing_q;
			end
			apcf_pkg::REQ_NEXT: begin
				desc.cmd  = apcf_pkg::CMD_NEXT;
				if (track_q < apcf_pkg::TRACK_MAX) begin
					track_d = track_q + 16'd1;
				end
				playing_d = 1'b1;
			end
			apcf_pkg::REQ_PREV: begin
				desc.cmd  = apcf_pkg::CMD_PREV;
				if (track_q > apcf_pkg::TRACK_MIN) begin
					track_d = track_q - 16'd1;
				end
				playing_d = 1'b1;
			end
			apcf_pkg::REQ_RESTART: begin
				desc.cmd   = apcf_pkg::CMD_FOLDER_TRACK;
				desc.param = {folder_q, track_q[7:0]};
				playing_d  = 1'b1;
			end
			apcf_pkg::REQ_TRACK: begin
				desc.cmd   = apcf_pkg::CMD_TRACK;
				desc.param = track_number;
				track_d    = track_number;
				playing_d  = 1'b1;
			end
			apcf_pkg::REQ_FOLDER_TRACK: begin
				desc.cmd   = apcf_pkg::CMD_FOLDER_TRACK;
				desc.param = {folder_number, track_number[7:0]};
				track_d    = track_number;
				folder_d   = folder_number;
				playing_d  = 1'b1;
			end
			apcf_pkg::REQ_VOLUME: begin
				desc.cmd   = apcf_pkg::CMD_VOLUME;
				desc.param = {11'd0, vol_sat};
				volume_d   = vol_sat;
			end
			apcf_pkg::REQ_SLEEP: begin
				desc.cmd  = apcf_pkg::CMD_PAUSE;
				desc.two  = 1'b1;
				playing_d = 1'b0;
			end
			default: begin
				known = 1'b0;
			end
		endcase
		desc.emit = known && link_enabled;
	end

	// State advances on every accepted request, whether or not the link is up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q   <= 16'd0;
			folder_q  <= 8'd0;
			volume_q  <= 5'd0;
			playing_q <= 1'b0;
		end else if (accept) begin
			track_q   <= track_d;
			folder_q  <= folder_d;
			volume_q  <= volume_d;
			playing_q <= playing_d;
		end
	end

endmodule

[rtl/core/audio_player_command_framer_core.sv]
// Top level of the audio player command framer: request slot, byte sequencer, output register.
`timescale 1ns / 1ps

// Usage. A request beat on req names a player action; the block updates its stored
// track, folder, volume and playing flag at that beat and turns the request into one
// ten-byte command frame (two frames for sleep), sent one byte per beat on frames.
// frame_end marks the closing EF byte of each frame, last marks the final byte that
// belongs to the request. Configuration beats on cfg set link_enabled (index 0) and
// ack_request (index 1); cfg is always ready. The user writes cfg only while the block
// is idle; the block itself does not enforce this. With the link disabled, requests
// still update the state but send no bytes. A request is held in the slot, then in the
// sequencer, then in the output register, before its first byte is valid on frames.
// The byte sequencer emits one byte per cycle while the receiver does not stall it;
// one decoded request waits in a slot meanwhile, so request beats and byte beats overlap
// and frames follow each other without gaps. Requests that send nothing are taken once
// per cycle while the slot is free. Reset clears the state, both registers, the slot and
// the output register. When the receiver stalls, the output register holds its byte,
// the sequencer stops, and req.ready falls once the slot is full.

module audio_player_command_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	apcf_req_if.sink    req,
	apcf_byte_if.source frames,
	apcf_cfg_if.sink    cfg
);

	logic link_enabled_q;
	logic ack_request_q;

	apcf_pkg::frame_desc_t dec_desc;
	logic                  req_accept;

	logic        slot_valid_s1;
	logic [7:0]  slot_cmd_s1;
	logic [15:0] slot_param_s1;
	logic        slot_two_s1;

	logic        seq_busy_q;
	logic [7:0]  seq_cmd_q;
	logic [15:0] seq_param_q;
	logic        seq_two_q;
	logic        seq_second_q;
	logic [3:0]  seq_idx_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_end_q;
	logic        out_last_q;

	logic        out_free;
	logic        seq_step;
	logic        seq_frame_end;
	logic        seq_final;
	logic        seq_load;
	logic [7:0]  seq_byte;

	// One byte of a frame, picked by its position; the checksum negates the byte sum.
	function automatic logic [7:0] frame_byte_at(input logic [7:0] cmd, input logic ack,
		input logic [15:0] param, input logic [3:0] idx);
		logic [15:0] sum;
		logic [15:0] chk;
		logic [7:0]  b;
		sum = {8'd0, apcf_pkg::FRAME_VERSION} + {8'd0, apcf_pkg::FRAME_LENGTH}
			+ {8'd0, cmd} + {15'd0, ack} + {8'd0, param[15:8]} + {8'd0, param[7:0]};
		chk = 16'd0 - sum;
		case (idx)
			apcf_pkg::IDX_START:   b = apcf_pkg::FRAME_START;
			apcf_pkg::IDX_VERSION: b = apcf_pkg::FRAME_VERSION;
			apcf_pkg::IDX_LENGTH:  b = apcf_pkg::FRAME_LENGTH;
			apcf_pkg::IDX_CMD:     b = cmd;
			apcf_pkg::IDX_ACK:     b = {7'd0, ack};
			apcf_pkg::IDX_PAR_HI:  b = param[15:8];
			apcf_pkg::IDX_PAR_LO:  b = param[7:0];
			apcf_pkg::IDX_CHK_HI:  b = chk[15:8];
			apcf_pkg::IDX_CHK_LO:  b = chk[7:0];
			default:               b = apcf_pkg::FRAME_STOP;
		endcase
		return b;
	endfunction

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_enabled_q <= 1'b0;
			ack_request_q  <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index == apcf_pkg::CFG_LINK_ENABLED) begin
				link_enabled_q <= cfg.data[0];
			end
			if (cfg.index == apcf_pkg::CFG_ACK_REQUEST) begin
				ack_request_q <= cfg.data[0];
			end
		end
	end

	// Request decoding and player state.
	apcf_req_state u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (req_accept),
		.link_enabled  (link_enabled_q),
		.req_type      (req.req_type),
		.track_number  (req.track_number),
		.folder_number (req.folder_number),
		.volume_level  (req.volume_level),
		.desc          (dec_desc)
	);

	// Sequencer control: step when the output register can take a byte.
	assign out_free      = !out_valid_q || frames.ready;
	assign seq_step      = seq_busy_q && out_free;
	assign seq_frame_end = (seq_idx_q == apcf_pkg::IDX_STOP);
	assign seq_final     = seq_frame_end && (!seq_two_q || seq_second_q);
	assign seq_load      = slot_valid_s1 && (!seq_busy_q || (seq_step && seq_final));
	assign req.ready     = !slot_valid_s1 || seq_load;
	assign req_accept    = req.valid && req.ready;
	assign seq_byte      = frame_byte_at(seq_cmd_q, ack_request_q, seq_param_q, seq_idx_q);

	// Request slot holding the next decoded request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_s1 <= 1'b0;
		end else begin
			slot_valid_s1 <= (slot_valid_s1 && !seq_load) || (req_accept && dec_desc.emit);
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			slot_cmd_s1   <= dec_desc.cmd;
			slot_param_s1 <= dec_desc.param;
			slot_two_s1   <= dec_desc.two;
		end
	end

	// Byte sequencer over one or two frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_busy_q   <= 1'b0;
			seq_second_q <= 1'b0;
			seq_idx_q    <= apcf_pkg::IDX_START;
		end else if (seq_load) begin
			seq_busy_q   <= 1'b1;
			seq_second_q <= 1'b0;
			seq_idx_q    <= apcf_pkg::IDX_START;
		end else if (seq_step) begin
			if (!seq_frame_end) begin
				seq_idx_q <= seq_idx_q + 4'd1;
			end else if (!seq_final) begin
				seq_second_q <= 1'b1;
				seq_idx_q    <= apcf_pkg::IDX_START;
			end else begin
				seq_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_load) begin
			seq_cmd_q   <= slot_cmd_s1;
			seq_param_q <= slot_param_s1;
			seq_two_q   <= slot_two_s1;
		end else if (seq_step && seq_frame_end && !seq_final) begin
			// The second frame of a sleep request carries the sleep command.
			seq_cmd_q   <= apcf_pkg::CMD_SLEEP;
			seq_param_q <= 16'h0000;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= seq_busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_step) begin
			out_byte_q <= seq_byte;
			out_end_q  <= seq_frame_end;
			out_last_q <= seq_final;
		end
	end

	assign frames.valid      = out_valid_q;
	assign frames.frame_byte = out_byte_q;
	assign frames.frame_end  = out_end_q;
	assign frames.last       = out_last_q;

endmodule

[rtl/core/apcf_checker.sv]
// Port checker of the audio player command framer and its bind to the top level.
`timescale 1ns / 1ps

module apcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic       frame_end,
	input logic       last
);

	logic beat;
	logic at_start_q;

	assign beat = out_valid && out_ready;

	// Tracks whether the next byte beat opens a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
		end else if (beat) begin
			at_start_q <= frame_end;
		end
	end

	// A closing byte is always the stop byte.
	a_end_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> (frame_byte == apcf_pkg::FRAME_STOP))
		else $error("frame_end set on a byte other than the stop byte");

	// The last byte of a request closes a frame.
	a_last_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> frame_end)
		else $error("last set on a byte that does not close a frame");

	// Every frame opens with the start byte.
	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && at_start_q) |-> (frame_byte == apcf_pkg::FRAME_START))
		else $error("frame does not open with the start byte");

	// A stalled byte holds.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(frame_byte)
		&& $stable(frame_end) && $stable(last)))
		else $error("stalled output byte changed");

endmodule

bind audio_player_command_framer_core apcf_checker u_apcf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (frames.valid),
	.out_ready  (frames.ready),
	.frame_byte (frames.frame_byte),
	.frame_end  (frames.frame_end),
	.last       (frames.last)
);
